>>> hw/rtl/icv_pkg.sv
// ----------------------------------------------------------------------------
// icv_pkg
// Shared types and constants of the interrupt coalescing vector unit.
// ----------------------------------------------------------------------------
package icv_pkg;

   localparam int REQ_TYPE_W = 3;
   localparam int VEC_W      = 4;
   localparam int TIME_W     = 32;
   localparam int CNT_W      = 8;
   localparam int THR_W      = 8;
   localparam int WIN_W      = 16;
   localparam int MASK_W     = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_RAISE       = 3'd0,
      REQ_COND_FIRE   = 3'd1,
      REQ_CLEAR       = 3'd2,
      REQ_DIRECT_FIRE = 3'd3,
      REQ_CLEAR_ALL   = 3'd4
   } req_type_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_WINDOW    = 2'd1,
      CSR_ENABLE    = 2'd2,
      CSR_CONNECTED = 2'd3
   } csr_addr_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } ctl_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctl_cmd_type;

   typedef struct packed {
      logic rsp_full;
   } dp_status_type;

endpackage

>>> hw/rtl/icv_ctrl.sv
// ----------------------------------------------------------------------------
// icv_ctrl
// Request sequencer: takes an item, runs it through the datapath once the
// result register can take the outcome.
// ----------------------------------------------------------------------------
module icv_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   rsp_tready,
   input  icv_pkg::dp_status_type status,
   output icv_pkg::ctl_cmd_type   cmd
);
   import icv_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;
   logic          out_free;

   assign out_free = !status.rsp_full || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free && !req_tvalid) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_EXEC: begin
            cmd.execute = out_free;
            req_tready  = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      cmd.capture = req_tvalid && req_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/icv_datapath.sv
// ----------------------------------------------------------------------------
// icv_datapath
// Per-vector pending counts and last fire times, coalescing decision,
// configuration registers and result register.
// ----------------------------------------------------------------------------
module icv_datapath #(
   parameter int VECTORS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  icv_pkg::ctl_cmd_type                 cmd,
   output icv_pkg::dp_status_type               status,
   input  logic [icv_pkg::REQ_TYPE_W-1:0]       in_req_type,
   input  logic [icv_pkg::VEC_W-1:0]            in_vector,
   input  logic [icv_pkg::TIME_W-1:0]           in_now,
   input  logic                                 csr_we,
   input  logic [icv_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [icv_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic                                 out_fired,
   output logic                                 out_signalled,
   output logic [icv_pkg::CNT_W-1:0]            out_pending
);
   import icv_pkg::*;

   localparam int REACH = 1 << VEC_W;
   localparam int DEPTH = (VECTORS < REACH) ? VECTORS : REACH;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [REQ_TYPE_W-1:0] req_type_ff;
   logic [VEC_W-1:0]      vec_ff;
   logic [TIME_W-1:0]     now_ff;

   logic [CNT_W-1:0]      cnt_ff  [DEPTH];
   logic [CNT_W-1:0]      cnt_in  [DEPTH];
   logic [TIME_W-1:0]     last_ff [DEPTH];
   logic [TIME_W-1:0]     last_in [DEPTH];

   logic [THR_W-1:0]      thr_ff;
   logic [WIN_W-1:0]      win_ff;
   logic [MASK_W-1:0]     en_ff;
   logic [MASK_W-1:0]     conn_ff;

   logic                  rsp_valid_ff;
   logic                  fired_ff;
   logic                  sig_ff;
   logic [CNT_W-1:0]      pend_ff;

   logic                  in_range;
   logic [IDX_W-1:0]      idx;
   logic [CNT_W-1:0]      cur_cnt;
   logic [TIME_W-1:0]     delta;
   logic                  held;
   logic                  fire;
   logic                  conn;
   logic [CNT_W-1:0]      new_cnt;

   assign in_range = 32'(vec_ff) < VECTORS;
   assign idx      = IDX_W'(vec_ff);
   assign cur_cnt  = in_range ? cnt_ff[idx] : '0;
   assign delta    = now_ff - (in_range ? last_ff[idx] : '0);
   assign conn     = conn_ff[vec_ff];
   assign held     = en_ff[vec_ff] && (cur_cnt < thr_ff)
                     && (delta < TIME_W'(win_ff));

   always_comb begin
      cnt_in  = cnt_ff;
      last_in = last_ff;
      fire    = 1'b0;
      new_cnt = cur_cnt;
      if (in_range) begin
         case (req_type_type'(req_type_ff))
            REQ_RAISE: begin
               if (cur_cnt != CNT_MAX) new_cnt = cur_cnt + 1'b1;
               cnt_in[idx] = new_cnt;
            end
            REQ_COND_FIRE: begin
               if (cur_cnt != '0 && !held) begin
                  fire         = 1'b1;
                  new_cnt      = '0;
                  cnt_in[idx]  = '0;
                  last_in[idx] = now_ff;
               end
            end
            REQ_CLEAR: begin
               new_cnt      = '0;
               cnt_in[idx]  = '0;
               last_in[idx] = now_ff;
            end
            REQ_DIRECT_FIRE: begin
               fire = 1'b1;
            end
            REQ_CLEAR_ALL: begin
               new_cnt = '0;
               for (int i = 0; i < DEPTH; i++) begin
                  cnt_in[i]  = '0;
                  last_in[i] = '0;
               end
            end
            default: begin
               new_cnt = cur_cnt;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff <= in_req_type;
         vec_ff      <= in_vector;
         now_ff      <= in_now;
      end
      if (cmd.execute) begin
         fired_ff <= fire;
         sig_ff   <= fire && conn && in_range;
         pend_ff  <= new_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            cnt_ff[i]  <= '0;
            last_ff[i] <= '0;
         end
         thr_ff       <= THR_W'(1);
         win_ff       <= '0;
         en_ff        <= '0;
         conn_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.execute) begin
            cnt_ff  <= cnt_in;
            last_ff <= last_in;
         end
         if (csr_we) begin
            unique case (csr_addr_type'(csr_addr))
               CSR_THRESHOLD: thr_ff  <= csr_wdata[THR_W-1:0];
               CSR_WINDOW:    win_ff  <= csr_wdata[WIN_W-1:0];
               CSR_ENABLE:    en_ff   <= csr_wdata[MASK_W-1:0];
               CSR_CONNECTED: conn_ff <= csr_wdata[MASK_W-1:0];
               default:       thr_ff  <= thr_ff;
            endcase
         end
         if (cmd.execute) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.rsp_full = rsp_valid_ff;
   assign rsp_tvalid      = rsp_valid_ff;
   assign out_fired       = fired_ff;
   assign out_signalled   = sig_ff;
   assign out_pending     = pend_ff;

endmodule

>>> hw/rtl/interrupt_coalescing_vectors_unit.sv
// Accept captures the item into the request registers; execute then loads the
// result register and raises rsp_tvalid. Throughput: 1 item per cycle while
// rsp_tready stays high; the single result register holds one item and stalls
// the execute stage while it is full and rsp_tready is low.
// Reset (synchronous, active high): all pending counts and last fire times
// zero, threshold 1, window 0, enable and connected masks clear.
// ----------------------------------------------------------------------------
// interrupt_coalescing_vectors_unit
// Per-vector interrupt coalescing: raise, conditional fire, clear, direct
// fire and clear all, one result item per request item.
// ----------------------------------------------------------------------------
module interrupt_coalescing_vectors_unit #(
   parameter int VECTORS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [2:0] req_type
   input  logic [icv_pkg::REQ_TYPE_W-1:0]     req_tuser,
   // [3:0] vector_index, [35:4] now_us, [39:36] zero
   input  logic [icv_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] fired, [1] signalled, [9:2] pending_after, [15:10] zero
   output logic [icv_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_we,
   input  logic [icv_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [icv_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import icv_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;
   logic          out_fired;
   logic          out_signalled;
   logic [CNT_W-1:0] out_pending;

   icv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   icv_datapath #(
      .VECTORS (VECTORS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .in_req_type   (req_tuser),
      .in_vector     (req_tdata[VEC_W-1:0]),
      .in_now        (req_tdata[VEC_W+TIME_W-1:VEC_W]),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .out_fired     (out_fired),
      .out_signalled (out_signalled),
      .out_pending   (out_pending)
   );

   assign rsp_tdata = {(RSP_DATA_W-CNT_W-2)'(0), out_pending, out_signalled, out_fired};

   a_sig_needs_fire : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[1] && !rsp_tdata[0]))
      else $error("signalled without fired");

   a_accept_runs : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> u_ctrl.state_ff == ST_EXEC)
      else $error("accepted item not executed");

   a_exec_loads : assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_tvalid)
      else $error("executed item produced no result");

endmodule
